/* hw/rtl/alc_pkg.sv */
// ----------------------------------------------------------------------------
// alc_pkg
// Shared widths, breakpoint thresholds and segment coefficients for the
// ambient light lux calculation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package alc_pkg;

    localparam int CountW   = 16;
    localparam int LuxW     = 16;
    localparam int CoefW    = 10;
    localparam int ThrW     = 11;
    localparam int RatioSh  = 10;
    localparam int GainSh   = 4;
    localparam int LuxSh    = 14;
    localparam int NumSegs  = 8;
    localparam int SegW     = $clog2(NumSegs);
    localparam int ProdW    = CountW + CoefW;
    localparam int ScaledW  = ProdW + GainSh;

    typedef logic [CountW-1:0] t_count;
    typedef logic [CoefW-1:0]  t_coef;
    typedef logic [ThrW-1:0]   t_thr;
    typedef logic [SegW-1:0]   t_seg;
    typedef logic [ProdW-1:0]  t_prod;
    typedef logic [LuxW-1:0]   t_lux;

    // 2*k+1 per breakpoint: ratio <= k  <=>  (ch1 << 10) < ch0 * (2k+1)
    function automatic t_thr seg_thr(input t_seg seg);
        t_thr thr;
        case (seg)
            3'd0:    thr = 11'd129;
            3'd1:    thr = 11'd257;
            3'd2:    thr = 11'd385;
            3'd3:    thr = 11'd513;
            3'd4:    thr = 11'd625;
            3'd5:    thr = 11'd821;
            3'd6:    thr = 11'd1333;
            default: thr = 11'd0;
        endcase
        return thr;
    endfunction

    function automatic t_coef seg_b(input t_seg seg);
        t_coef b;
        case (seg)
            3'd0:    b = 10'h1f2;
            3'd1:    b = 10'h214;
            3'd2:    b = 10'h23f;
            3'd3:    b = 10'h270;
            3'd4:    b = 10'h16f;
            3'd5:    b = 10'h0d2;
            3'd6:    b = 10'h018;
            default: b = 10'h000;
        endcase
        return b;
    endfunction

    function automatic t_coef seg_m(input t_seg seg);
        t_coef m;
        case (seg)
            3'd0:    m = 10'h1be;
            3'd1:    m = 10'h2d1;
            3'd2:    m = 10'h37b;
            3'd3:    m = 10'h3fe;
            3'd4:    m = 10'h1fc;
            3'd5:    m = 10'h0fb;
            3'd6:    m = 10'h012;
            default: m = 10'h000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/alc_in_if.sv */
// ----------------------------------------------------------------------------
// alc_in_if
// Input item channel: one pair of raw photodiode counts.
// ----------------------------------------------------------------------------
`default_nettype none

interface alc_in_if;
    logic                   valid;
    logic                   ready;
    logic [alc_pkg::CountW-1:0] broadband_count;
    logic [alc_pkg::CountW-1:0] infrared_count;

    modport source (output valid, output broadband_count, output infrared_count,
                    input ready);
    modport sink   (input valid, input broadband_count, input infrared_count,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/alc_out_if.sv */
// ----------------------------------------------------------------------------
// alc_out_if
// Result item channel: illuminance in whole lux.
// ----------------------------------------------------------------------------
`default_nettype none

interface alc_out_if;
    logic                     valid;
    logic                     ready;
    logic [alc_pkg::LuxW-1:0] lux;

    modport source (output valid, output lux, input ready);
    modport sink   (input valid, input lux, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ambient_light_lux_calc_unit.sv */
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_unit
// Lux from channel 0 / channel 1 photodiode counts, T package, 402 ms
// integration, as a four stage pipeline.
//
//   channel   dir   handshake       payload
//   s_in      in    valid/ready     broadband_count[15:0], infrared_count[15:0]
//   m_out     out   valid/ready     lux[15:0]
//   cfg       in    i_cfg_we        i_cfg_wdata (gain_x16)
//
// One item per cycle while m_out is ready.
// Stages: input register, breakpoint compare, products, round/saturate.
// Each stage advances when it is empty or the next one moves, so bubbles
// collapse under output stall and nothing is dropped or repeated.
// Reset clears the stage valid bits and sets gain_x16 to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_light_lux_calc_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    alc_in_if.sink    s_in,
    alc_out_if.source m_out
);
    import alc_pkg::*;

    logic   r_gain_x16;
    logic   r_v1;
    logic   r_v2;
    logic   r_v3;
    logic   r_v4;
    logic   w_en1;
    logic   w_en2;
    logic   w_en3;
    logic   w_en4;
    t_count r_c0;
    t_count r_c1;
    logic   r_g1;
    t_count w_c0_2;
    t_count w_c1_2;
    logic   w_g2;
    t_seg   w_seg2;
    t_prod  w_pos3;
    t_prod  w_neg3;
    logic   w_g3;
    t_lux   w_lux4;

    assign w_en4 = !r_v4 || m_out.ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_x16 <= 1'b0;
        end else if (i_cfg_we) begin
            r_gain_x16 <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= s_in.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_c0 <= s_in.broadband_count;
            r_c1 <= s_in.infrared_count;
            r_g1 <= r_gain_x16;
        end
    end

    alc_seg_sel u_seg_sel (
        .i_clk      (i_clk),
        .i_en       (w_en2),
        .i_c0       (r_c0),
        .i_c1       (r_c1),
        .i_gain_x16 (r_g1),
        .o_c0       (w_c0_2),
        .o_c1       (w_c1_2),
        .o_gain_x16 (w_g2),
        .o_seg      (w_seg2)
    );

    alc_mult u_mult (
        .i_clk      (i_clk),
        .i_en       (w_en3),
        .i_c0       (w_c0_2),
        .i_c1       (w_c1_2),
        .i_gain_x16 (w_g2),
        .i_seg      (w_seg2),
        .o_pos      (w_pos3),
        .o_neg      (w_neg3),
        .o_gain_x16 (w_g3)
    );

    alc_round u_round (
        .i_clk      (i_clk),
        .i_en       (w_en4),
        .i_pos      (w_pos3),
        .i_neg      (w_neg3),
        .i_gain_x16 (w_g3),
        .o_lux      (w_lux4)
    );

    assign s_in.ready  = w_en1;
    assign m_out.valid = r_v4;
    assign m_out.lux   = w_lux4;

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_in.ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && !m_out.ready))
        else $error("input blocked while pipeline has a free stage");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in.valid && s_in.ready) |=> r_v1)
        else $error("accepted item missing from stage 1");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_en3) |=> (r_v2 && $stable(w_seg2) && $stable(w_c0_2)))
        else $error("stalled stage 2 item changed");

    a_stage3_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && w_en4) |=> r_v4)
        else $error("stage 3 item lost on advance");

endmodule

`default_nettype wire

/* hw/rtl/alc_seg_sel.sv */
// ----------------------------------------------------------------------------
// alc_seg_sel
// Pipeline stage 2: compares the count ratio against all breakpoints by
// cross multiplication and registers the selected segment.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_seg_sel (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire alc_pkg::t_count i_c0,
    input  wire alc_pkg::t_count i_c1,
    input  wire logic           i_gain_x16,
    output alc_pkg::t_count     o_c0,
    output alc_pkg::t_count     o_c1,
    output logic                o_gain_x16,
    output alc_pkg::t_seg       o_seg
);
    import alc_pkg::*;

    localparam int CmpW = CountW + ThrW;

    logic [NumSegs-2:0] w_le;
    logic [CmpW-1:0]    w_num;
    t_seg               n_seg;
    t_count             r_c0;
    t_count             r_c1;
    logic               r_gain_x16;
    t_seg               r_seg;

    assign w_num = {{(CmpW-CountW-RatioSh){1'b0}}, i_c1, {RatioSh{1'b0}}};

    always_comb begin
        for (int i = 0; i < NumSegs - 1; i++) begin
            w_le[i] = (i_c0 == '0) ||
                      (w_num < CmpW'(i_c0) * CmpW'(seg_thr(SegW'(i))));
        end
        n_seg = SegW'(NumSegs - 1);
        for (int i = NumSegs - 2; i >= 0; i--) begin
            if (w_le[i]) begin
                n_seg = SegW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0       <= i_c0;
            r_c1       <= i_c1;
            r_gain_x16 <= i_gain_x16;
            r_seg      <= n_seg;
        end
    end

    assign o_c0       = r_c0;
    assign o_c1       = r_c1;
    assign o_gain_x16 = r_gain_x16;
    assign o_seg      = r_seg;

endmodule

`default_nettype wire

/* hw/rtl/alc_mult.sv */
// ----------------------------------------------------------------------------
// alc_mult
// Pipeline stage 3: looks up slope and intercept and forms both products
// on the raw counts.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_mult (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire alc_pkg::t_count i_c0,
    input  wire alc_pkg::t_count i_c1,
    input  wire logic            i_gain_x16,
    input  wire alc_pkg::t_seg   i_seg,
    output alc_pkg::t_prod       o_pos,
    output alc_pkg::t_prod       o_neg,
    output logic                 o_gain_x16
);
    import alc_pkg::*;

    t_prod r_pos;
    t_prod r_neg;
    logic  r_gain_x16;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos      <= ProdW'(i_c0) * ProdW'(seg_b(i_seg));
            r_neg      <= ProdW'(i_c1) * ProdW'(seg_m(i_seg));
            r_gain_x16 <= i_gain_x16;
        end
    end

    assign o_pos      = r_pos;
    assign o_neg      = r_neg;
    assign o_gain_x16 = r_gain_x16;

endmodule

`default_nettype wire

/* hw/rtl/alc_round.sv */
// ----------------------------------------------------------------------------
// alc_round
// Pipeline stage 4: applies gain scaling, clamps the difference at zero,
// rounds, saturates and registers the lux value.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_round (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire alc_pkg::t_prod i_pos,
    input  wire alc_pkg::t_prod i_neg,
    input  wire logic           i_gain_x16,
    output alc_pkg::t_lux       o_lux
);
    import alc_pkg::*;

    localparam int SumW = ScaledW + 1;
    localparam int QW   = SumW - LuxSh;

    logic [ScaledW-1:0] w_pos;
    logic [ScaledW-1:0] w_neg;
    logic [ScaledW-1:0] w_diff;
    logic [SumW-1:0]    w_sum;
    logic [QW-1:0]      w_q;
    t_lux               n_lux;
    t_lux               r_lux;

    always_comb begin
        w_pos  = i_gain_x16 ? ScaledW'(i_pos) : {i_pos, {GainSh{1'b0}}};
        w_neg  = i_gain_x16 ? ScaledW'(i_neg) : {i_neg, {GainSh{1'b0}}};
        w_diff = (w_pos > w_neg) ? (w_pos - w_neg) : '0;
        w_sum  = SumW'(w_diff) + (SumW'(1) << (LuxSh - 1));
        w_q    = w_sum[SumW-1:LuxSh];
        n_lux  = (w_q > QW'({LuxW{1'b1}})) ? {LuxW{1'b1}} : w_q[LuxW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lux <= n_lux;
        end
    end

    assign o_lux = r_lux;

endmodule

`default_nettype wire

/* bench/ambient_light_lux_calc_unit_tb.sv */
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_unit_tb
// Self-checking bench for the lux pipeline. Count pairs are pushed through
// the input channel with random gaps, and lux items are drained with random
// back-pressure (one random phase uses neither). Every item is predicted when
// it is accepted, and each lux item is compared in order. Runs go at both
// gain settings, with directed corner pairs first and then random pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_light_lux_calc_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alc_pkg::*;

    localparam logic GAIN_X1          = 1'b0;
    localparam logic GAIN_X16         = 1'b1;
    localparam int   RANDOM_PER_PHASE = 500;
    localparam int   STALL_LIMIT      = 2000;
    localparam int   PIPE_DEPTH       = 4;
    localparam int   REPORT_MAX       = 10;

    class lux_scoreboard;
        logic gain_x16;
        t_lux pending_lux[$];
        int   faults;
        int   checked;

        function new();
            gain_x16 = GAIN_X1;
            faults   = 0;
            checked  = 0;
        endfunction

        function t_lux predict_lux(t_count bb, t_count ir);
            longint unsigned c0, c1, ratio, b, m, pos, neg, sum;
            c0 = bb;
            c1 = ir;
            if (!gain_x16) begin
                c0 = c0 << GainSh;
                c1 = c1 << GainSh;
            end
            ratio = 0;
            if (c0 != 0)
                ratio = (c1 << RatioSh) / c0;
            ratio = (ratio + 1) >> 1;
            if (ratio <= 'h040) begin
                b = 'h1f2; m = 'h1be;
            end else if (ratio <= 'h080) begin
                b = 'h214; m = 'h2d1;
            end else if (ratio <= 'h0c0) begin
                b = 'h23f; m = 'h37b;
            end else if (ratio <= 'h100) begin
                b = 'h270; m = 'h3fe;
            end else if (ratio <= 'h138) begin
                b = 'h16f; m = 'h1fc;
            end else if (ratio <= 'h19a) begin
                b = 'h0d2; m = 'h0fb;
            end else if (ratio <= 'h29a) begin
                b = 'h018; m = 'h012;
            end else begin
                b = 0; m = 0;
            end
            pos = c0 * b;
            neg = c1 * m;
            sum = (pos > neg) ? pos - neg : 0;
            sum = (sum + (64'd1 << (LuxSh - 1))) >> LuxSh;
            if (sum > 'hFFFF)
                sum = 'hFFFF;
            return t_lux'(sum);
        endfunction

        function void note_counts(t_count bb, t_count ir);
            pending_lux.push_back(predict_lux(bb, ir));
        endfunction

        function void check_lux(t_lux got);
            t_lux want;
            checked++;
            if (pending_lux.size() == 0) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("lux item %0d arrived with nothing pending", got);
                return;
            end
            want = pending_lux.pop_front();
            if (got !== want) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("lux mismatch at item %0d: expected %0d, got %0d",
                             checked, want, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    bit   no_idle;
    int   idle_cycles;
    int   sent_items;

    lux_scoreboard sb = new();

    alc_in_if  counts_if ();
    alc_out_if lux_if ();

    ambient_light_lux_calc_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_in        (counts_if),
        .m_out       (lux_if)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        lux_if.ready <= no_idle || ($urandom_range(99) >= 19);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (counts_if.valid && counts_if.ready)
                sb.note_counts(counts_if.broadband_count, counts_if.infrared_count);
            if (lux_if.valid && lux_if.ready)
                sb.check_lux(lux_if.lux);
            if ((counts_if.valid && counts_if.ready) || (lux_if.valid && lux_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("no item moved for %0d cycles", STALL_LIMIT);
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_counts(input t_count bb, input t_count ir);
        while (!no_idle && $urandom_range(99) < 19) begin
            counts_if.valid = 1'b0;
            @(negedge i_clk);
        end
        counts_if.broadband_count = bb;
        counts_if.infrared_count  = ir;
        counts_if.valid           = 1'b1;
        @(posedge i_clk);
        while (!counts_if.ready)
            @(posedge i_clk);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        counts_if.valid = 1'b0;
        while (sb.pending_lux.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_gain(input logic gain);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = gain;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.gain_x16 = gain;
    endtask

    task automatic run_corners;
        int unsigned knees[7] = '{64, 128, 192, 256, 312, 410, 666};
        push_counts(16'd0, 16'd0);
        push_counts(16'd0, 16'hFFFF);
        push_counts(16'hFFFF, 16'd0);
        push_counts(16'hFFFF, 16'hFFFF);
        push_counts(16'd1, 16'd1);
        push_counts(16'hFFFF, 16'd1);
        // ratio lands exactly on each breakpoint, then just past it
        foreach (knees[i]) begin
            push_counts(16'd512, t_count'(knees[i]));
            push_counts(16'd512, t_count'(knees[i] + 1));
        end
        push_counts(16'd512, 16'd700);
        push_counts(16'd100, 16'd60000);
    endtask

    task automatic pick_counts(output t_count bb, output t_count ir);
        int unsigned width;
        int unsigned slope;
        int unsigned scaled;
        case ($urandom_range(9))
            0: begin
                bb = t_count'($urandom);
                ir = t_count'($urandom);
            end
            1: begin
                bb = t_count'($urandom_range(15));
                ir = t_count'($urandom_range(15));
            end
            2: begin
                bb = '0;
                ir = t_count'($urandom);
            end
            default: begin
                width  = $urandom_range(16, 1);
                bb     = t_count'($urandom & ((32'd1 << width) - 1));
                slope  = $urandom_range(760);
                scaled = (32'(bb) * slope) >> 9;
                ir     = (scaled > 32'hFFFF) ? 16'hFFFF : t_count'(scaled);
            end
        endcase
    endtask

    initial begin
        logic   gains[4];
        t_count bb;
        t_count ir;
        gains                     = '{GAIN_X1, GAIN_X16, GAIN_X1, GAIN_X16};
        i_clk                     = 1'b0;
        i_rst_n                   = 1'b0;
        i_cfg_we                  = 1'b0;
        i_cfg_wdata               = 1'b0;
        counts_if.valid           = 1'b0;
        counts_if.broadband_count = '0;
        counts_if.infrared_count  = '0;
        lux_if.ready              = 1'b0;
        no_idle                   = 1'b0;
        idle_cycles               = 0;
        sent_items                = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_gain(GAIN_X16);
        run_corners();
        drain();
        write_gain(GAIN_X1);
        run_corners();
        drain();

        foreach (gains[p]) begin
            write_gain(gains[p]);
            no_idle = (p == 2);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (p == 1 && n == RANDOM_PER_PHASE / 2)
                    drain();
                pick_counts(bb, ir);
                push_counts(bb, ir);
            end
            drain();
        end
        no_idle = 1'b0;

        repeat (PIPE_DEPTH * 2) @(posedge i_clk);
        sb.faults += sb.pending_lux.size();
        $display("Sent %0d count pairs and checked %0d lux items", sent_items, sb.checked);
        $display("covering both gain settings, all breakpoints and random ratios");
        if (sb.faults == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
